// File: rtl/rsa_pkg.sv
// Shared constants, types and the sigmoid table for the ReLU / sigmoid activation unit.
// Self-contained; imported by relu_sigmoid_activation_unit.

package rsa_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int FRAC_BITS     = 12;
    localparam int DATA_W        = 16;
    localparam int ABS_W         = DATA_W - 1;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PROD_W        = ABS_W + $clog2(TABLE_ENTRIES + 1);
    localparam int S_W           = FRAC_BITS + 1;
    localparam int D_W           = FRAC_BITS + 2;
    localparam int SQ_W          = 2 * S_W;
    localparam int HALVINGS      = 10;

    localparam logic [S_W-1:0] ONE_Q   = S_W'(1) << FRAC_BITS;
    localparam logic [63:0]    Q60_ONE = 64'd1 << 60;
    localparam logic [63:0]    ROM_H   =
        (64'd1 << (60 + 15 - FRAC_BITS - HALVINGS)) / 64'(TABLE_ENTRIES);

    typedef enum logic {
        REG_ACT_KIND = 1'b0,
        REG_PASS_DIR = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ACT_RELU    = 1'b0,
        ACT_SIGMOID = 1'b1
    } t_act;

    typedef enum logic {
        DIR_FORWARD  = 1'b0,
        DIR_BACKWARD = 1'b1
    } t_dir;

    typedef logic [S_W-1:0] t_rom_word;
    typedef t_rom_word      t_rom [0:TABLE_ENTRIES];

    // Per-item control carried alongside the datapath
    typedef struct packed {
        t_act                     act;
        t_dir                     dir;
        logic                     last;
        logic                     neg;
        logic signed [DATA_W-1:0] relu;
        logic signed [DATA_W-1:0] grad;
    } t_side;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        return full[123:60];
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // T[k] = round(2^FRAC_BITS / (1 + exp(-k*step))), exp by series and repeated squaring
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] q2;
        sum  = Q60_ONE;
        term = Q60_ONE;
        for (int n = 1; n <= 12; n++) begin
            term = udiv64(mul_q60(term, ROM_H), 64'(n));
            if ((n & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        r = sum;
        for (int n = 0; n < HALVINGS; n++) begin
            r = mul_q60(r, r);
        end
        e = Q60_ONE;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            den    = (Q60_ONE + e) >> 20;
            q2     = udiv64(64'd1 << (FRAC_BITS + 41), den);
            rom[k] = S_W'((q2 + 64'd1) >> 1);
            e      = mul_q60(e, r);
        end
        return rom;
    endfunction

    localparam t_rom SIG_ROM = build_rom();

endpackage

// File: rtl/relu_sigmoid_activation_unit.sv
// Top level of the ReLU / sigmoid activation unit: five-stage pipeline and register port.
// Depends on rsa_pkg.
//
//   channel  direction  handshake                         payload
//   input    in         i_in_valid / o_in_stall           i_x_value, i_grad_in, i_last_in
//   output   out        o_out_valid / i_out_stall         o_y_value, o_last_out
//   config   in         psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled; a result is offered through the register
// stages abs/index, table read, interpolation, s*(1-s) and gradient multiply.
// Reset clears the valid bits and sets both registers to zero.
// A stall fills bubbles first and holds each full stage; nothing is dropped or repeated.

module relu_sigmoid_activation_unit
    import rsa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_x_value,
    input  logic signed [DATA_W-1:0] i_grad_in,
    input  logic                     i_last_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_y_value,
    output logic                     o_last_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    t_act r_act_kind;
    t_dir r_pass_dir;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    t_side r_side1, r_side2, r_side3, r_side4;

    logic [IDX_W-1:0]  r_idx1;
    logic [ABS_W-1:0]  r_frac1, r_frac2;
    t_rom_word         r_t0_2;
    logic signed [D_W-1:0] r_d2;
    logic [S_W-1:0]    r_s3;
    logic [S_W-1:0]    r_s4;
    logic [SQ_W-1:0]   r_sq4;

    logic signed [DATA_W-1:0] r_y5;
    logic                     r_last5;
    t_act                     r_act5;
    t_dir                     r_dir5;

    t_side               n_side1;
    logic [ABS_W-1:0]    w_abs;
    logic [PROD_W-1:0]   w_prod;
    logic [IDX_W:0]      w_idx_lo;
    logic [IDX_W:0]      w_idx_hi;
    t_rom_word           w_t0;
    t_rom_word           w_t1;
    logic signed [D_W+ABS_W:0] w_interp;
    logic signed [D_W+ABS_W:0] w_step;
    logic [S_W-1:0]      w_s_pos;
    logic [S_W-1:0]      n_s3;
    logic [SQ_W-1:0]     n_sq4;
    logic signed [SQ_W+DATA_W:0] w_gprod;
    logic signed [DATA_W-1:0]    n_y5;
    logic                        w_cfg_wr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_kind <= ACT_RELU;
            r_pass_dir <= DIR_FORWARD;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_ACT_KIND: r_act_kind <= t_act'(pwdata[0]);
                REG_PASS_DIR: r_pass_dir <= t_dir'(pwdata[0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_ACT_KIND: prdata = {31'd0, r_act_kind};
            REG_PASS_DIR: prdata = {31'd0, r_pass_dir};
            default:      prdata = '0;
        endcase
    end

    // stage advance: fill bubbles, hold full stages under stall
    assign w_rdy5     = !r_v5 || !i_out_stall;
    assign w_rdy4     = !r_v4 || w_rdy5;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // stage 1: magnitude, table index and fraction, ReLU result
    always_comb begin
        if (!i_x_value[DATA_W-1]) begin
            w_abs = i_x_value[ABS_W-1:0];
        end else if (i_x_value == {1'b1, {ABS_W{1'b0}}}) begin
            w_abs = '1;
        end else begin
            w_abs = ABS_W'(-i_x_value);
        end
        w_prod       = PROD_W'(w_abs) * PROD_W'(TABLE_ENTRIES);
        n_side1.act  = r_act_kind;
        n_side1.dir  = r_pass_dir;
        n_side1.last = i_last_in;
        n_side1.neg  = i_x_value[DATA_W-1];
        n_side1.grad = i_grad_in;
        if (i_x_value > 0) begin
            n_side1.relu = (r_pass_dir == DIR_FORWARD) ? i_x_value : i_grad_in;
        end else begin
            n_side1.relu = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_side1 <= n_side1;
            r_idx1  <= w_prod[ABS_W +: IDX_W];
            r_frac1 <= w_prod[ABS_W-1:0];
        end
    end

    // stage 2: table read
    assign w_idx_lo = {1'b0, r_idx1};
    assign w_idx_hi = w_idx_lo + (IDX_W+1)'(1);
    assign w_t0     = SIG_ROM[w_idx_lo];
    assign w_t1     = SIG_ROM[w_idx_hi];

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_side2 <= r_side1;
            r_frac2 <= r_frac1;
            r_t0_2  <= w_t0;
            r_d2    <= $signed({1'b0, w_t1}) - $signed({1'b0, w_t0});
        end
    end

    // stage 3: interpolate, mirror for negative input
    assign w_interp = r_d2 * $signed({1'b0, r_frac2});
    assign w_step   = w_interp >>> ABS_W;
    assign w_s_pos  = r_t0_2 + w_step[S_W-1:0];
    assign n_s3     = r_side2.neg ? (ONE_Q - w_s_pos) : w_s_pos;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_side3 <= r_side2;
            r_s3    <= n_s3;
        end
    end

    // stage 4: s * (1 - s)
    assign n_sq4 = SQ_W'(r_s3) * SQ_W'(ONE_Q - r_s3);

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_side4 <= r_side3;
            r_s4    <= r_s3;
            r_sq4   <= n_sq4;
        end
    end

    // stage 5: gradient product and result select
    assign w_gprod = $signed({1'b0, r_sq4}) * $signed(r_side4.grad);

    always_comb begin
        if (r_side4.act == ACT_RELU) begin
            n_y5 = r_side4.relu;
        end else if (r_side4.dir == DIR_FORWARD) begin
            n_y5 = $signed(DATA_W'(r_s4));
        end else begin
            n_y5 = w_gprod[2*FRAC_BITS +: DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_y5    <= n_y5;
            r_last5 <= r_side4.last;
            r_act5  <= r_side4.act;
            r_dir5  <= r_side4.dir;
        end
    end

    assign o_out_valid = r_v5;
    assign o_y_value   = r_y5;
    assign o_last_out  = r_last5;

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_out_stall))
        else $error("input stalled with a bubble in the pipeline");

    a_relu_fwd_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_act5 == ACT_RELU && r_dir5 == DIR_FORWARD) |-> !o_y_value[DATA_W-1])
        else $error("negative ReLU forward result");

    a_sig_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_act5 == ACT_SIGMOID && r_dir5 == DIR_FORWARD)
            |-> (o_y_value >= 0 && o_y_value <= $signed(DATA_W'(ONE_Q))))
        else $error("sigmoid forward result out of range");
`endif

endmodule
